### hw/rtl/cdt_pkg.sv
// ---------------------------------------------------------------------------
// cdt_pkg: shared constants and types for the countdown timer table
// Table size, field widths, command codes and the subtract unit result.
// ---------------------------------------------------------------------------
package cdt_pkg;

    localparam int TIMERS  = 16;
    localparam int IDX_W   = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CNT_W   = $clog2(TIMERS + 1);

    localparam int MODE_W  = 2;
    localparam int ID_W    = 4;
    localparam int DELAY_W = 22;
    localparam int STEP_W  = 20;
    localparam int REM_W   = 31;
    localparam int PEND_W  = 5;
    localparam int PROD_W  = 32;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(50000);
    localparam logic [9:0]        MS_TO_US   = 10'd1000;
    localparam logic [REM_W-1:0]  REM_MAX    = {REM_W{1'b1}};

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK       = 2'd0,
        MODE_ARM        = 2'd1,
        MODE_CANCEL     = 2'd2,
        MODE_CANCEL_ALL = 2'd3
    } t_mode;

    typedef struct packed {
        logic             expire;
        logic [REM_W-1:0] diff;
    } t_alu_out;

endpackage

### hw/rtl/cdt_intf.sv
// ---------------------------------------------------------------------------
// cdt_intf: valid/ready channels of the countdown timer table
// Command channel, result channel and the tick step write channel.
// ---------------------------------------------------------------------------
interface cdt_cmd_if;
    import cdt_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [ID_W-1:0]    timer_id;
    logic [DELAY_W-1:0] delay_ms;

    modport source (output valid, output mode, output timer_id, output delay_ms,
                    input ready);
    modport sink   (input valid, input mode, input timer_id, input delay_ms,
                    output ready);
endinterface

interface cdt_res_if;
    import cdt_pkg::*;

    logic              valid;
    logic              ready;
    logic              fired;
    logic [ID_W-1:0]   fired_id;
    logic              last;
    logic [PEND_W-1:0] pending;

    modport source (output valid, output fired, output fired_id, output last,
                    output pending, input ready);
    modport sink   (input valid, input fired, input fired_id, input last,
                    input pending, output ready);
endinterface

interface cdt_cfg_if;
    import cdt_pkg::*;

    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] tick_step_us;

    modport source (output valid, output tick_step_us, input ready);
    modport sink   (input valid, input tick_step_us, output ready);
endinterface

### hw/rtl/cdt_ram.sv
// ---------------------------------------------------------------------------
// cdt_ram: generic single write, single read RAM
// One write port, one read port with registered read data held between reads.
// ---------------------------------------------------------------------------
module cdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/cdt_alu.sv
// ---------------------------------------------------------------------------
// cdt_alu: shared subtract and compare unit
// Takes the tick step from a remainder and flags an entry that expires.
// ---------------------------------------------------------------------------
module cdt_alu (
    input  logic [cdt_pkg::REM_W-1:0]  i_rem,
    input  logic [cdt_pkg::STEP_W-1:0] i_step,
    output cdt_pkg::t_alu_out          o_out
);
    import cdt_pkg::*;

    logic [REM_W:0] diff;

    // borrow out or a zero difference means the remainder is not above the step
    assign diff         = {1'b0, i_rem} - (REM_W + 1)'(i_step);
    assign o_out.expire = diff[REM_W] || (diff[REM_W-1:0] == '0);
    assign o_out.diff   = diff[REM_W-1:0];

endmodule

### hw/rtl/countdown_timer_table.sv
// ---------------------------------------------------------------------------
// countdown_timer_table: table of one-shot countdown timers
// Sequencer walking the remainder RAM through a shared subtract unit.
// ---------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command word: tick, arm, cancel one, cancel all.
//   o_res returns result words; i_cfg writes the tick step (microseconds).
//   Arm, cancel and cancel-all give one word, registered from S_EXEC.
//   A tick walks all 16 entries through the single subtract unit, one entry
//   a cycle, each from its registered RAM read, then scans the fired list one
//   entry a cycle unless a stalled receiver holds it, giving one word per
//   fired timer in ascending number, or a single word when none fired.
//   Commands are taken one at a time: i_cmd.ready is high only while idle.
//   A word waiting in the output register does not block the next accept;
//   a stalled receiver holds the sequencer only when a new word is due.
//   Every word carries the pending count after the whole command.
//   Reset frees every timer and loads the default tick step of 50000 us;
//   the remainder RAM is not cleared, a free entry's read data is never used.
//   i_cfg.ready is always high; write the step only while the block is idle.
// ---------------------------------------------------------------------------
module countdown_timer_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdt_cmd_if.sink    i_cmd,
    cdt_res_if.source  o_res,
    cdt_cfg_if.sink    i_cfg
);
    import cdt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WALK = 4'b0100,
        S_SCAN = 4'b1000
    } t_state;

    localparam int EXT_W = (IDX_W > ID_W) ? IDX_W : ID_W;
    localparam logic [IDX_W:0] LAST_IDX = (IDX_W + 1)'(TIMERS);

    // control state
    t_state             r_state, n_state;
    logic [TIMERS-1:0]  r_live, n_live;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_fire, n_fire;
    logic [CNT_W-1:0]   r_emit, n_emit;
    logic [IDX_W:0]     r_idx, n_idx;
    logic [STEP_W-1:0]  r_step;
    logic               r_ovalid, n_ovalid;

    // payload
    t_mode              r_mode, n_mode;
    logic [ID_W-1:0]    r_id, n_id;
    logic [DELAY_W-1:0] r_delay, n_delay;
    logic [TIMERS-1:0]  r_mask, n_mask;
    logic               r_ofired, n_ofired;
    logic [ID_W-1:0]    r_oid, n_oid;
    logic               r_olast, n_olast;
    logic [PEND_W-1:0]  r_opend, n_opend;

    logic               out_free;
    logic               id_ok;
    logic [EXT_W-1:0]   id_ext;
    logic [IDX_W-1:0]   id_idx;
    logic [IDX_W:0]     proc_full;
    logic [IDX_W-1:0]   proc_idx;
    logic [IDX_W-1:0]   scan_idx;
    logic [EXT_W-1:0]   scan_ext;
    logic [PROD_W-1:0]  arm_prod;
    logic [REM_W-1:0]   arm_us;
    logic               emit_last;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [REM_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [REM_W-1:0]   ram_rdata;
    t_alu_out           alu_out;

    cdt_ram #(
        .WIDTH (REM_W),
        .DEPTH (TIMERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    cdt_alu u_alu (
        .i_rem  (ram_rdata),
        .i_step (r_step),
        .o_out  (alu_out)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_res.valid    = r_ovalid;
    assign o_res.fired    = r_ofired;
    assign o_res.fired_id = r_oid;
    assign o_res.last     = r_olast;
    assign o_res.pending  = r_opend;

    assign out_free  = !r_ovalid || o_res.ready;
    assign id_ok     = (32'(r_id) < 32'(TIMERS));
    assign id_ext    = EXT_W'(r_id);
    assign id_idx    = id_ext[IDX_W-1:0];
    assign proc_full = r_idx - (IDX_W + 1)'(1);
    assign proc_idx  = proc_full[IDX_W-1:0];
    assign scan_idx  = r_idx[IDX_W-1:0];
    assign scan_ext  = EXT_W'(scan_idx);
    assign emit_last = ((r_emit + CNT_W'(1)) == r_fire);

    // scale to microseconds and saturate to the remainder width
    assign arm_prod = PROD_W'(r_delay) * PROD_W'(MS_TO_US);
    assign arm_us   = (arm_prod > PROD_W'(REM_MAX)) ? REM_MAX : arm_prod[REM_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_live    = r_live;
        n_cnt     = r_cnt;
        n_fire    = r_fire;
        n_emit    = r_emit;
        n_idx     = r_idx;
        n_mode    = r_mode;
        n_id      = r_id;
        n_delay   = r_delay;
        n_mask    = r_mask;
        n_ofired  = r_ofired;
        n_oid     = r_oid;
        n_olast   = r_olast;
        n_opend   = r_opend;
        ram_we    = 1'b0;
        ram_waddr = proc_idx;
        ram_wdata = alu_out.diff;
        ram_re    = 1'b0;
        n_ovalid  = o_res.ready ? 1'b0 : r_ovalid;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_mode  = t_mode'(i_cmd.mode);
                    n_id    = i_cmd.timer_id;
                    n_delay = i_cmd.delay_ms;
                    if (t_mode'(i_cmd.mode) == MODE_TICK) begin
                        n_state = S_WALK;
                        n_idx   = '0;
                        n_fire  = '0;
                        n_mask  = '0;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    unique case (r_mode)
                        MODE_ARM: begin
                            if (id_ok) begin
                                ram_we    = 1'b1;
                                ram_waddr = id_idx;
                                ram_wdata = arm_us;
                                n_live[id_idx] = 1'b1;
                                if (!r_live[id_idx]) begin
                                    n_cnt = r_cnt + CNT_W'(1);
                                end
                            end
                        end
                        MODE_CANCEL: begin
                            if (id_ok && r_live[id_idx]) begin
                                n_live[id_idx] = 1'b0;
                                n_cnt = r_cnt - CNT_W'(1);
                            end
                        end
                        MODE_CANCEL_ALL: begin
                            n_live = '0;
                            n_cnt  = '0;
                        end
                        MODE_TICK: begin
                            n_cnt = r_cnt;
                        end
                    endcase
                    n_ovalid = 1'b1;
                    n_ofired = 1'b0;
                    n_oid    = '0;
                    n_olast  = 1'b1;
                    n_opend  = PEND_W'(n_cnt);
                    n_state  = S_IDLE;
                end
            end
            S_WALK: begin
                // read entry idx while the unit works on entry idx - 1
                ram_re = (r_idx < LAST_IDX);
                n_idx  = r_idx + (IDX_W + 1)'(1);
                if (r_idx != '0 && r_live[proc_idx]) begin
                    if (alu_out.expire) begin
                        n_live[proc_idx] = 1'b0;
                        n_mask[proc_idx] = 1'b1;
                        n_cnt  = r_cnt - CNT_W'(1);
                        n_fire = r_fire + CNT_W'(1);
                    end else begin
                        ram_we = 1'b1;
                    end
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                    n_emit  = '0;
                end
            end
            S_SCAN: begin
                if (r_fire == '0) begin
                    if (out_free) begin
                        n_ovalid = 1'b1;
                        n_ofired = 1'b0;
                        n_oid    = '0;
                        n_olast  = 1'b1;
                        n_opend  = PEND_W'(r_cnt);
                        n_state  = S_IDLE;
                    end
                end else if (r_mask[scan_idx]) begin
                    if (out_free) begin
                        n_ovalid = 1'b1;
                        n_ofired = 1'b1;
                        n_oid    = scan_ext[ID_W-1:0];
                        n_olast  = emit_last;
                        n_opend  = PEND_W'(r_cnt);
                        n_emit   = r_emit + CNT_W'(1);
                        n_idx    = r_idx + (IDX_W + 1)'(1);
                        if (emit_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    n_idx = r_idx + (IDX_W + 1)'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_live   <= '0;
            r_cnt    <= '0;
            r_fire   <= '0;
            r_emit   <= '0;
            r_idx    <= '0;
            r_step   <= STEP_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_live   <= n_live;
            r_cnt    <= n_cnt;
            r_fire   <= n_fire;
            r_emit   <= n_emit;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
            if (i_cfg.valid) begin
                r_step <= i_cfg.tick_step_us;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_id     <= n_id;
        r_delay  <= n_delay;
        r_mask   <= n_mask;
        r_ofired <= n_ofired;
        r_oid    <= n_oid;
        r_olast  <= n_olast;
        r_opend  <= n_opend;
    end

endmodule

### tb/cdt_timer_checker.sv
// ---------------------------------------------------------------------------
// cdt_timer_checker: result checker for the countdown timer table
// Watches the command, result and tick step channels, keeps its own copy of
// the timer table, predicts every result word and compares it field by field.
// ---------------------------------------------------------------------------
module cdt_timer_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    cdt_cmd_if   i_cmd,
    cdt_res_if   i_res,
    cdt_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_waiting
);
    import cdt_pkg::*;

    typedef struct packed {
        logic              fired;
        logic [ID_W-1:0]   fired_id;
        logic              last;
        logic [PEND_W-1:0] pending;
    } t_word;

    t_word             due_words [$];
    logic [TIMERS-1:0] live_mask;
    logic [REM_W-1:0]  rem_us [TIMERS];
    logic [STEP_W-1:0] step_us;
    int                err_cnt = 0;

    task automatic advance_timers(input t_mode m, input logic [ID_W-1:0] id,
                                  input logic [DELAY_W-1:0] delay_ms);
        int                fired_ids [$];
        logic [63:0]       load_us;
        logic [PEND_W-1:0] pend;
        t_word             w;
        case (m)
            MODE_TICK: begin
                // visit in ascending number, expire at or below the step
                for (int i = 0; i < TIMERS; i++) begin
                    if (live_mask[i]) begin
                        if (rem_us[i] > REM_W'(step_us)) begin
                            rem_us[i] = rem_us[i] - REM_W'(step_us);
                        end else begin
                            live_mask[i] = 1'b0;
                            fired_ids.push_back(i);
                        end
                    end
                end
            end
            MODE_ARM: begin
                if (int'(id) < TIMERS) begin
                    load_us = 64'(delay_ms) * 64'(MS_TO_US);
                    rem_us[id] = (load_us > 64'(REM_MAX)) ? REM_MAX : load_us[REM_W-1:0];
                    live_mask[id] = 1'b1;
                end
            end
            MODE_CANCEL: begin
                if (int'(id) < TIMERS) live_mask[id] = 1'b0;
            end
            default: begin
                live_mask = '0;
            end
        endcase
        pend = PEND_W'($countones(live_mask));
        if (fired_ids.size() == 0) begin
            w = '{fired: 1'b0, fired_id: '0, last: 1'b1, pending: pend};
            due_words.push_back(w);
        end else begin
            foreach (fired_ids[k]) begin
                w = '{fired: 1'b1, fired_id: ID_W'(fired_ids[k]),
                      last: (k == fired_ids.size() - 1), pending: pend};
                due_words.push_back(w);
            end
        end
    endtask

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        err_cnt++;
        // keep the log short on a badly broken block
        if (err_cnt <= 100)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    task automatic check_word();
        t_word w;
        if (due_words.size() == 0) begin
            err_cnt++;
            $display({"%0t: unexpected result word, expected none, ",
                      "got fired=%0d id=%0d last=%0d pending=%0d"},
                     $time, i_res.fired, i_res.fired_id, i_res.last, i_res.pending);
        end else begin
            w = due_words.pop_front();
            if (w.fired !== i_res.fired)
                flag_field("fired", 32'(w.fired), 32'(i_res.fired));
            if (w.fired_id !== i_res.fired_id)
                flag_field("fired_id", 32'(w.fired_id), 32'(i_res.fired_id));
            if (w.last !== i_res.last)
                flag_field("last", 32'(w.last), 32'(i_res.last));
            if (w.pending !== i_res.pending)
                flag_field("pending", 32'(w.pending), 32'(i_res.pending));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            live_mask = '0;
            step_us   = STEP_RESET;
            due_words.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) step_us = i_cfg.tick_step_us;
            // a word leaving now belongs to an earlier command
            if (i_res.valid && i_res.ready) check_word();
            if (i_cmd.valid && i_cmd.ready)
                advance_timers(t_mode'(i_cmd.mode), i_cmd.timer_id, i_cmd.delay_ms);
        end
        o_errors  <= err_cnt;
        o_waiting <= due_words.size();
    end

endmodule

### tb/tb_countdown_timer_table.sv
// ---------------------------------------------------------------------------
// tb_countdown_timer_table: testbench top for the countdown timer table
// Drives commands and tick step writes, stalls the result channel, and runs
// phases with different steps and idling; the checker does the comparing.
// ---------------------------------------------------------------------------
module tb_countdown_timer_table;
    import cdt_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int END_CYCLES = 64;
    localparam int PHASE_ITEMS = 50;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int errors;
    int words_due;
    int items_sent = 0;
    int words_seen = 0;
    int fires_seen = 0;
    int quiet      = 0;
    int send_idle  = 0;
    int stall_pct  = 0;

    logic [STEP_W-1:0] step_now = STEP_RESET;

    cdt_cmd_if cmd_ch ();
    cdt_res_if res_ch ();
    cdt_cfg_if cfg_ch ();

    countdown_timer_table dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    cdt_timer_checker chk (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cmd     (cmd_ch),
        .i_res     (res_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (errors),
        .o_waiting (words_due)
    );

    always #1 clk = ~clk;

    // result receiver: stall at the rate of the current phase
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles with no word moving, plus run totals
    always @(posedge clk) begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet <= 0;
        end else if (quiet == IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
        if (rst_n && res_ch.valid && res_ch.ready) begin
            words_seen <= words_seen + 1;
            if (res_ch.fired) fires_seen <= fires_seen + 1;
        end
    end

    task automatic send_cmd(input t_mode m, input logic [ID_W-1:0] id,
                            input logic [DELAY_W-1:0] delay_ms);
        while ($urandom_range(99) < send_idle) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.mode     <= m;
        cmd_ch.timer_id <= id;
        cmd_ch.delay_ms <= delay_ms;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    // hold the sender until every predicted word has come back
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0) @(posedge clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] step);
        drain();
        cfg_ch.valid        <= 1'b1;
        cfg_ch.tick_step_us <= step;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        step_now = step;
    endtask

    // mostly delays that expire within a few ticks of the current step
    function automatic logic [DELAY_W-1:0] pick_delay();
        int unsigned pick;
        int unsigned ms_top;
        pick   = $urandom_range(99);
        ms_top = step_now / 1000 * 6 + 2;
        if (pick < 85) return DELAY_W'($urandom_range(ms_top, 0));
        if (pick < 95) return DELAY_W'($urandom);
        if (pick < 98) return '1;
        return DELAY_W'(2147483);
    endfunction

    task automatic run_random(input int n_items);
        int          start_cnt;
        int unsigned pick;
        start_cnt = items_sent;
        // a full table of zero delays, so the next tick fires every entry
        for (int i = 0; i < TIMERS; i++) send_cmd(MODE_ARM, ID_W'(i), '0);
        send_cmd(MODE_TICK, ID_W'($urandom), DELAY_W'($urandom));
        while (items_sent - start_cnt < n_items) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                for (int i = 0; i < TIMERS; i++)
                    if ($urandom_range(3) != 0) send_cmd(MODE_ARM, ID_W'(i), pick_delay());
                repeat ($urandom_range(4, 1))
                    send_cmd(MODE_TICK, ID_W'($urandom), DELAY_W'($urandom));
            end else if (pick < 14) begin
                send_cmd(t_mode'($urandom_range(3)), ID_W'($urandom), DELAY_W'($urandom));
            end else if (pick < 16) begin
                send_cmd(MODE_CANCEL_ALL, ID_W'($urandom), DELAY_W'($urandom));
            end else if (pick < 18) begin
                drain();
            end else begin
                pick = $urandom_range(99);
                if (pick < 45)
                    send_cmd(MODE_TICK, ID_W'($urandom), DELAY_W'($urandom));
                else if (pick < 80)
                    send_cmd(MODE_ARM, ID_W'($urandom), pick_delay());
                else
                    send_cmd(MODE_CANCEL, ID_W'($urandom), DELAY_W'($urandom));
            end
        end
    endtask

    initial begin
        cmd_ch.valid        = 1'b0;
        cmd_ch.mode         = MODE_TICK;
        cmd_ch.timer_id     = '0;
        cmd_ch.delay_ms     = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.tick_step_us = STEP_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default step of 50 ms
        send_cmd(MODE_TICK, '0, '0);
        send_cmd(MODE_ARM, 4'd0, '0);
        send_cmd(MODE_ARM, 4'd15, DELAY_W'(50));
        send_cmd(MODE_ARM, 4'd7, DELAY_W'(51));
        send_cmd(MODE_ARM, 4'd3, '1);
        send_cmd(MODE_ARM, 4'd8, DELAY_W'(2147483));
        send_cmd(MODE_ARM, 4'd5, DELAY_W'(1000));
        send_cmd(MODE_ARM, 4'd5, '0);
        send_cmd(MODE_TICK, '1, '1);
        send_cmd(MODE_TICK, '0, '0);
        send_cmd(MODE_CANCEL, 4'd3, '0);
        send_cmd(MODE_CANCEL, 4'd3, '1);
        send_cmd(MODE_CANCEL, 4'd9, '0);
        send_cmd(MODE_CANCEL_ALL, '1, '1);
        send_cmd(MODE_TICK, '0, '0);
        run_random(PHASE_ITEMS);

        write_step('0);
        send_idle = 46;
        run_random(PHASE_ITEMS);

        write_step('1);
        send_idle = 0;
        stall_pct <= 46;
        run_random(PHASE_ITEMS);

        write_step(STEP_W'(1000));
        send_idle = 25;
        stall_pct <= 25;
        run_random(PHASE_ITEMS);

        write_step(STEP_W'(1));
        send_idle = 0;
        stall_pct <= 0;
        run_random(PHASE_ITEMS);

        drain();
        repeat (END_CYCLES) @(posedge clk);

        $display("tb: %0d commands over tick steps of 50000, 0, 1048575, 1000 and 1 us",
                 items_sent);
        $display("tb: %0d result words checked, %0d of them timer expiries",
                 words_seen, fires_seen);
        if (errors == 0 && words_due == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
